// ===== rtl/latency_histogram_stats_defines.svh =====
// Assertion macros shared by the latency statistics checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LATENCY_HISTOGRAM_STATS_DEFINES_SVH
`define LATENCY_HISTOGRAM_STATS_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define LHS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("latency stats assertion failed");

// Next-cycle implication, disabled while in reset
`define LHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("latency stats assertion failed");

// Next-cycle implication that also holds across reset
`define LHS_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("latency stats reset assertion failed");

`endif

// ===== rtl/lhs_pkg.sv =====
// Shared types, constants and command codes for the latency statistics block.
// No dependencies; used by every RTL module but lhs_ram and lhs_checker.
package lhs_pkg;

    // Default geometry
    localparam int BUCKET_WIDTH_NS = 1000;
    localparam int NUM_BUCKETS     = 1024;
    localparam int QUEUE_DEPTH     = 4;

    // Field widths
    localparam int DATA_W    = 64;
    localparam int FRAC_W    = 17;
    localparam int BKT_W     = 32;
    localparam int IDX_MAX_W = 16;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // Command codes
    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Classified word passed from front to back
    typedef struct packed {
        logic [1:0]           cmd;
        logic [DATA_W-1:0]    sample;
        logic [FRAC_W-1:0]    frac;
        logic                 ovf;
        logic [IDX_MAX_W-1:0] idx;
    } t_work;

    // One result word
    typedef struct packed {
        logic [DATA_W-1:0] min_latency;
        logic [DATA_W-1:0] max_latency;
        logic [DATA_W-1:0] sample_sum;
        logic [DATA_W-1:0] sample_count;
        logic [DATA_W-1:0] overflow_count;
        logic [DATA_W-1:0] mean_latency;
        logic [DATA_W-1:0] percentile_latency;
    } t_result;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_BKT,
        BK_MUL,
        BK_WALK_RD,
        BK_WALK_CHK,
        BK_DIV,
        BK_DIV_WAIT,
        BK_OUT
    } t_back_state;

endpackage

// ===== rtl/lhs_ifs.sv =====
// Valid/ready channel interfaces for command and result words.
// Depends on lhs_pkg for field widths.
interface lhs_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [lhs_pkg::DATA_W-1:0]    sample_nanos;
    logic [lhs_pkg::FRAC_W-1:0]    pct_fraction;

    modport source (output valid, command, sample_nanos, pct_fraction, input ready);
    modport sink   (input valid, command, sample_nanos, pct_fraction, output ready);
endinterface

interface lhs_out_if;
    logic                       valid;
    logic                       ready;
    logic [lhs_pkg::DATA_W-1:0] min_latency;
    logic [lhs_pkg::DATA_W-1:0] max_latency;
    logic [lhs_pkg::DATA_W-1:0] sample_sum;
    logic [lhs_pkg::DATA_W-1:0] sample_count;
    logic [lhs_pkg::DATA_W-1:0] overflow_count;
    logic [lhs_pkg::DATA_W-1:0] mean_latency;
    logic [lhs_pkg::DATA_W-1:0] percentile_latency;

    modport source (output valid, min_latency, max_latency, sample_sum, sample_count,
                    overflow_count, mean_latency, percentile_latency, input ready);
    modport sink   (input valid, min_latency, max_latency, sample_sum, sample_count,
                    overflow_count, mean_latency, percentile_latency, output ready);
endinterface

// ===== rtl/lhs_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module lhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/lhs_div.sv =====
// Restoring divider, one quotient bit per cycle, for the running mean.
// Depends on lhs_pkg for the request/response structs.
module lhs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lhs_pkg::t_div_req i_req,
    output lhs_pkg::t_div_rsp o_rsp
);
    localparam int DW     = lhs_pkg::DATA_W;
    localparam int STEP_W = $clog2(DW);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_quo;
    logic [DW-1:0]     r_dvsr;

    logic [DW:0]   rem_shift;
    logic [DW:0]   diff;
    logic [DW-1:0] n_rem;
    logic [DW-1:0] n_quo;

    // one shift-subtract step
    always_comb begin
        rem_shift = {r_rem, r_quo[DW-1]};
        diff      = rem_shift - {1'b0, r_dvsr};
        if (!diff[DW]) begin
            n_rem = diff[DW-1:0];
            n_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            n_rem = rem_shift[DW-1:0];
            n_quo = {r_quo[DW-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_dvsr <= i_req.divisor;
            r_step <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ===== rtl/lhs_fifo.sv =====
// Short queue of classified words between the front and back sections.
// Depends on lhs_pkg for the word type.
module lhs_fifo #(
    parameter int DEPTH = lhs_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lhs_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output lhs_pkg::t_work o_data,
    output logic           o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lhs_pkg::t_work   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== rtl/lhs_front.sv =====
// Front section: takes command words, saturates the fraction, flags overflow
// and finds the bucket index by reciprocal multiplication. Depends on lhs_pkg, lhs_ifs.
module lhs_front #(
    parameter int BUCKET_WIDTH_NS = lhs_pkg::BUCKET_WIDTH_NS,
    parameter int NUM_BUCKETS     = lhs_pkg::NUM_BUCKETS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lhs_in_if.sink         i_in,
    input  logic           i_enable,
    output logic           o_push,
    output lhs_pkg::t_work o_item,
    input  logic           i_full
);
    localparam int DW     = lhs_pkg::DATA_W;
    localparam int FW     = lhs_pkg::FRAC_W;
    localparam int IW     = lhs_pkg::IDX_MAX_W;
    localparam int IDX_W  = $clog2(NUM_BUCKETS);
    localparam int EDGE_W = IDX_W + $clog2(BUCKET_WIDTH_NS) + 1;
    // in-range samples stay below 2**(EDGE_W-1); a rounded-up reciprocal
    // scaled by 2**SHIFT then gives the exact quotient
    localparam int SHIFT  = EDGE_W - 1 + $clog2(BUCKET_WIDTH_NS);
    localparam int DIG_W  = 16;
    localparam int NDIG   = (EDGE_W + DIG_W - 1) / DIG_W;
    localparam int RCP_W  = NDIG * DIG_W;
    localparam int PART_W = EDGE_W + DIG_W;
    localparam int PROD_W = EDGE_W + RCP_W;
    localparam int STEP_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SHIFT) + 64'(BUCKET_WIDTH_NS) - 64'd1) / 64'(BUCKET_WIDTH_NS);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_FULL);
    localparam logic [DW-1:0] LIMIT = DW'(NUM_BUCKETS) * DW'(BUCKET_WIDTH_NS);

    lhs_pkg::t_front_state r_state;
    lhs_pkg::t_front_state n_state;

    lhs_pkg::t_work    r_item;
    logic [EDGE_W-1:0] r_smp;
    logic [RCP_W-1:0]  r_rcp;
    logic [STEP_W-1:0] r_step;
    logic [PROD_W-1:0] r_prod;

    logic              accept;
    logic              in_ovf;
    logic              in_div;
    logic [FW-1:0]     in_frac;
    logic [DIG_W-1:0]  rcp_dig;
    logic [PART_W-1:0] part;
    logic [PROD_W-1:0] n_prod;

    // classify the incoming word
    assign accept  = i_in.valid && i_in.ready;
    assign in_ovf  = (i_in.command == lhs_pkg::CMD_RECORD) && (i_in.sample_nanos >= LIMIT);
    assign in_div  = (i_in.command == lhs_pkg::CMD_RECORD) && !in_ovf;
    assign in_frac = (i_in.pct_fraction > lhs_pkg::FRAC_ONE) ? lhs_pkg::FRAC_ONE
                                                              : i_in.pct_fraction;

    // sample times one 16-bit digit of the reciprocal, top digit first
    always_comb begin
        rcp_dig = r_rcp[RCP_W-1 -: DIG_W];
        part    = PART_W'(r_smp) * PART_W'(rcp_dig);
        n_prod  = (r_prod << DIG_W) + PROD_W'(part);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lhs_pkg::FR_IDLE: begin
                if (accept) begin
                    n_state = in_div ? lhs_pkg::FR_DIV : lhs_pkg::FR_PUSH;
                end
            end
            lhs_pkg::FR_DIV: begin
                if (r_step == '0) begin
                    n_state = lhs_pkg::FR_PUSH;
                end
            end
            lhs_pkg::FR_PUSH: begin
                if (!i_full) begin
                    n_state = lhs_pkg::FR_IDLE;
                end
            end
            default: n_state = lhs_pkg::FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = (r_state == lhs_pkg::FR_IDLE) && i_enable;
        o_push     = (r_state == lhs_pkg::FR_PUSH) && !i_full;
        o_item     = r_item;
        o_item.idx = IW'(r_prod[SHIFT +: IDX_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lhs_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // word capture and multiply steps
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.cmd    <= i_in.command;
            r_item.sample <= i_in.sample_nanos;
            r_item.frac   <= in_frac;
            r_item.ovf    <= in_ovf;
            r_item.idx    <= '0;
            r_smp         <= EDGE_W'(i_in.sample_nanos);
            r_rcp         <= RECIP;
            r_step        <= STEP_W'(NDIG - 1);
            r_prod        <= '0;
        end else if (r_state == lhs_pkg::FR_DIV) begin
            r_prod <= n_prod;
            r_rcp  <= r_rcp << DIG_W;
            r_step <= r_step - STEP_W'(1);
        end
    end
endmodule

// ===== rtl/lhs_back.sv =====
// Back section: statistics registers, histogram RAM, percentile walk and mean.
// Depends on lhs_pkg, lhs_ifs, lhs_ram and lhs_div.
module lhs_back #(
    parameter int BUCKET_WIDTH_NS = lhs_pkg::BUCKET_WIDTH_NS,
    parameter int NUM_BUCKETS     = lhs_pkg::NUM_BUCKETS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lhs_pkg::t_work i_item,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_init_done,
    lhs_out_if.source      o_out
);
    localparam int DW      = lhs_pkg::DATA_W;
    localparam int FW      = lhs_pkg::FRAC_W;
    localparam int BW      = lhs_pkg::BKT_W;
    localparam int IDX_W   = $clog2(NUM_BUCKETS);
    localparam int EDGE_W  = IDX_W + $clog2(BUCKET_WIDTH_NS) + 1;
    localparam int ACC_W   = BW + IDX_W;
    localparam int PROD_W  = DW + FW;
    localparam int MSTEP_W = $clog2(FW);

    lhs_pkg::t_back_state r_state;
    lhs_pkg::t_back_state n_state;

    logic [IDX_W-1:0]   r_addr;
    logic               r_sweep_reply;
    logic               r_init_done;
    logic [DW-1:0]      r_min;
    logic [DW-1:0]      r_max;
    logic [DW-1:0]      r_sum;
    logic [DW-1:0]      r_cnt;
    logic [DW-1:0]      r_ovf;
    logic [DW-1:0]      r_pct;
    logic [DW-1:0]      r_mean;
    logic [PROD_W-1:0]  r_prod;
    logic [FW-1:0]      r_mplier;
    logic [MSTEP_W-1:0] r_mstep;
    logic [DW-1:0]      r_target;
    logic [ACC_W-1:0]   r_acc;
    logic [EDGE_W-1:0]  r_edge;
    lhs_pkg::t_result   r_out;
    logic               r_out_vld;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    logic [BW-1:0]     ram_wdata;
    logic [BW-1:0]     ram_rdata;
    lhs_pkg::t_div_req div_req;
    lhs_pkg::t_div_rsp div_rsp;
    logic              out_load;

    logic              last_addr;
    logic              last_mstep;
    logic [PROD_W-1:0] n_prod;
    logic [ACC_W-1:0]  n_acc;
    logic              walk_hit;

    // histogram store
    lhs_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // mean divider
    lhs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // shared datapath terms
    always_comb begin
        last_addr  = r_addr == IDX_W'(NUM_BUCKETS - 1);
        last_mstep = r_mstep == MSTEP_W'(FW - 1);
        n_prod     = (r_prod << 1) + (r_mplier[FW-1] ? PROD_W'(r_cnt) : PROD_W'(0));
        n_acc      = r_acc + ACC_W'(ram_rdata);
        walk_hit   = DW'(n_acc) >= r_target;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lhs_pkg::BK_SWEEP: begin
                if (last_addr) begin
                    n_state = r_sweep_reply ? lhs_pkg::BK_DIV : lhs_pkg::BK_IDLE;
                end
            end
            lhs_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    unique case (i_item.cmd)
                        lhs_pkg::CMD_RECORD:
                            n_state = i_item.ovf ? lhs_pkg::BK_DIV : lhs_pkg::BK_BKT;
                        lhs_pkg::CMD_QUERY:
                            n_state = (r_cnt == '0) ? lhs_pkg::BK_DIV : lhs_pkg::BK_MUL;
                        lhs_pkg::CMD_CLEAR:
                            n_state = lhs_pkg::BK_SWEEP;
                        default:
                            n_state = lhs_pkg::BK_DIV;
                    endcase
                end
            end
            lhs_pkg::BK_BKT:     n_state = lhs_pkg::BK_DIV;
            lhs_pkg::BK_MUL: begin
                if (last_mstep) begin
                    n_state = lhs_pkg::BK_WALK_RD;
                end
            end
            lhs_pkg::BK_WALK_RD: n_state = lhs_pkg::BK_WALK_CHK;
            lhs_pkg::BK_WALK_CHK: begin
                n_state = (walk_hit || last_addr) ? lhs_pkg::BK_DIV : lhs_pkg::BK_WALK_RD;
            end
            lhs_pkg::BK_DIV: begin
                n_state = (r_cnt == '0) ? lhs_pkg::BK_OUT : lhs_pkg::BK_DIV_WAIT;
            end
            lhs_pkg::BK_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = lhs_pkg::BK_OUT;
                end
            end
            lhs_pkg::BK_OUT: begin
                if (out_load) begin
                    n_state = lhs_pkg::BK_IDLE;
                end
            end
            default: n_state = lhs_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop            = (r_state == lhs_pkg::BK_IDLE) && !i_empty;
        out_load         = (r_state == lhs_pkg::BK_OUT) && (!r_out_vld || o_out.ready);
        div_req.start    = (r_state == lhs_pkg::BK_DIV) && (r_cnt != '0);
        div_req.dividend = r_sum;
        div_req.divisor  = r_cnt;
        ram_we           = 1'b0;
        ram_wdata        = '0;
        ram_addr         = r_addr;
        unique case (r_state)
            lhs_pkg::BK_SWEEP: begin
                ram_we = 1'b1;
            end
            lhs_pkg::BK_IDLE: begin
                ram_addr = IDX_W'(i_item.idx);
            end
            lhs_pkg::BK_BKT: begin
                // saturating increment
                ram_we    = 1'b1;
                ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + BW'(1);
            end
            default: begin
                ram_addr = r_addr;
            end
        endcase
    end

    // state, control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lhs_pkg::BK_SWEEP;
            r_addr        <= '0;
            r_sweep_reply <= 1'b0;
            r_init_done   <= 1'b0;
            r_out_vld     <= 1'b0;
            r_min         <= '1;
            r_max         <= '0;
            r_sum         <= '0;
            r_cnt         <= '0;
            r_ovf         <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= out_load || (r_out_vld && !o_out.ready);
            unique case (r_state)
                lhs_pkg::BK_SWEEP: begin
                    r_addr <= last_addr ? '0 : r_addr + IDX_W'(1);
                    if (last_addr) begin
                        r_init_done   <= 1'b1;
                        r_sweep_reply <= 1'b0;
                    end
                end
                lhs_pkg::BK_IDLE: begin
                    if (!i_empty) begin
                        unique case (i_item.cmd)
                            lhs_pkg::CMD_RECORD: begin
                                if (i_item.sample < r_min) begin
                                    r_min <= i_item.sample;
                                end
                                if (i_item.sample > r_max) begin
                                    r_max <= i_item.sample;
                                end
                                r_sum <= r_sum + i_item.sample;
                                r_cnt <= r_cnt + DW'(1);
                                if (i_item.ovf) begin
                                    r_ovf <= r_ovf + DW'(1);
                                end
                                r_addr <= IDX_W'(i_item.idx);
                            end
                            lhs_pkg::CMD_QUERY: begin
                                r_addr <= '0;
                            end
                            lhs_pkg::CMD_CLEAR: begin
                                r_min         <= '1;
                                r_max         <= '0;
                                r_sum         <= '0;
                                r_cnt         <= '0;
                                r_ovf         <= '0;
                                r_addr        <= '0;
                                r_sweep_reply <= 1'b1;
                            end
                            default: begin
                                r_addr <= r_addr;
                            end
                        endcase
                    end
                end
                lhs_pkg::BK_WALK_CHK: begin
                    if (!walk_hit && !last_addr) begin
                        r_addr <= r_addr + IDX_W'(1);
                    end
                end
                default: begin
                    r_addr <= r_addr;
                end
            endcase
        end
    end

    // query, mean and result payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lhs_pkg::BK_IDLE: begin
                r_pct    <= '0;
                r_prod   <= '0;
                r_mplier <= i_item.frac;
                r_mstep  <= '0;
            end
            lhs_pkg::BK_MUL: begin
                // count * p, MSB of p first
                r_prod   <= n_prod;
                r_mplier <= r_mplier << 1;
                r_mstep  <= r_mstep + MSTEP_W'(1);
                r_target <= n_prod[PROD_W-2:FW-1];
                r_acc    <= '0;
                r_edge   <= EDGE_W'(BUCKET_WIDTH_NS);
            end
            lhs_pkg::BK_WALK_CHK: begin
                r_acc  <= n_acc;
                r_edge <= r_edge + EDGE_W'(BUCKET_WIDTH_NS);
                if (walk_hit) begin
                    r_pct <= DW'(r_edge);
                end else if (last_addr) begin
                    r_pct <= r_max;
                end
            end
            lhs_pkg::BK_DIV: begin
                r_mean <= '0;
            end
            lhs_pkg::BK_DIV_WAIT: begin
                if (div_rsp.done) begin
                    r_mean <= div_rsp.quotient;
                end
            end
            default: begin
                r_pct <= r_pct;
            end
        endcase
        if (out_load) begin
            r_out.min_latency        <= r_min;
            r_out.max_latency        <= r_max;
            r_out.sample_sum         <= r_sum;
            r_out.sample_count       <= r_cnt;
            r_out.overflow_count     <= r_ovf;
            r_out.mean_latency       <= r_mean;
            r_out.percentile_latency <= r_pct;
        end
    end

    assign o_init_done              = r_init_done;
    assign o_out.valid              = r_out_vld;
    assign o_out.min_latency        = r_out.min_latency;
    assign o_out.max_latency        = r_out.max_latency;
    assign o_out.sample_sum         = r_out.sample_sum;
    assign o_out.sample_count       = r_out.sample_count;
    assign o_out.overflow_count     = r_out.overflow_count;
    assign o_out.mean_latency       = r_out.mean_latency;
    assign o_out.percentile_latency = r_out.percentile_latency;
endmodule

// ===== rtl/latency_histogram_stats.sv =====
// Latency statistics engine. Each command word (record, percentile query,
// clear) produces one result word with min, max, wrapping sum, count, overflow
// count, mean and the query answer. A front section takes a word, saturates the
// fraction and, for an in-range record, finds the bucket index by multiplying
// with the reciprocal of the bucket width, one 16-bit reciprocal digit per step;
// a QUEUE_DEPTH-word queue feeds the back section. The back section's 64-step
// mean divider sets the pace, and the back section takes no new word until the
// last result is loaded. A query adds 17 multiply steps for count*p and a read
// and a check per bucket walked, up to NUM_BUCKETS buckets, through the single
// histogram RAM port. A clear sweeps the whole RAM. After reset the RAM is
// swept with input ready held low.
// Depends on lhs_pkg, lhs_ifs, lhs_front, lhs_fifo and lhs_back.
module latency_histogram_stats #(
    parameter int BUCKET_WIDTH_NS = lhs_pkg::BUCKET_WIDTH_NS,
    parameter int NUM_BUCKETS     = lhs_pkg::NUM_BUCKETS,
    parameter int QUEUE_DEPTH     = lhs_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lhs_in_if.sink    i_in,
    lhs_out_if.source o_out
);
    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    logic           init_done;
    lhs_pkg::t_work push_item;
    lhs_pkg::t_work head_item;

    // command intake and classification
    lhs_front #(
        .BUCKET_WIDTH_NS (BUCKET_WIDTH_NS),
        .NUM_BUCKETS     (NUM_BUCKETS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_enable (init_done),
        .o_push   (push),
        .o_item   (push_item),
        .i_full   (full)
    );

    // decoupling queue
    lhs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_empty (empty)
    );

    // statistics and histogram
    lhs_back #(
        .BUCKET_WIDTH_NS (BUCKET_WIDTH_NS),
        .NUM_BUCKETS     (NUM_BUCKETS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_init_done (init_done),
        .o_out       (o_out)
    );
endmodule

// ===== rtl/lhs_checker.sv =====
// Port-level checker for the latency statistics block, bound to the top level.
// Depends on latency_histogram_stats_defines.svh for the assertion macros.
`include "latency_histogram_stats_defines.svh"

module lhs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_min,
    input logic [63:0] i_out_max,
    input logic [63:0] i_out_count,
    input logic [63:0] i_out_ovf,
    input logic [63:0] i_out_mean
);
    // a result word waits until taken
    `LHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // reset quiets both channels while the RAM is swept
    `LHS_ASSERT_RESET(a_reset_quiet, i_clk, !i_rst_n, !i_in_ready && !i_out_valid)

    // an empty tracker reports reset statistics
    `LHS_ASSERT_SAME(a_empty_stats, i_clk, i_rst_n, i_out_valid && i_out_count == 64'd0, i_out_min == 64'hFFFF_FFFF_FFFF_FFFF && i_out_max == 64'd0 && i_out_mean == 64'd0)

    // with samples, min never exceeds max and overflows never exceed the count
    `LHS_ASSERT_SAME(a_order, i_clk, i_rst_n, i_out_valid && i_out_count != 64'd0, i_out_min <= i_out_max && i_out_ovf <= i_out_count)
endmodule

bind latency_histogram_stats lhs_checker u_lhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_min   (o_out.min_latency),
    .i_out_max   (o_out.max_latency),
    .i_out_count (o_out.sample_count),
    .i_out_ovf   (o_out.overflow_count),
    .i_out_mean  (o_out.mean_latency)
);

// ===== verif/tb_latency_histogram_stats.sv =====
// Self-checking testbench for latency_histogram_stats: directed and random command words,
// a statistics predictor and a scoreboard that checks every result word in order.
// Depends on rtl/lhs_pkg.sv, rtl/lhs_ifs.sv and the latency_histogram_stats RTL.
module tb_latency_histogram_stats;
    timeunit 1ns;
    timeprecision 1ps;
    import lhs_pkg::*;

    // Code 3 is not decoded by the block: it only reports the statistics
    localparam logic [1:0]        CMD_UNUSED   = 2'd3;
    localparam logic [DATA_W-1:0] ALL_ONES     = '1;
    localparam int                RANDOM_WORDS = 1100;
    localparam int                HIST_SPAN_NS = NUM_BUCKETS * BUCKET_WIDTH_NS;
    localparam int                DRAIN_CYCLES = 2 * NUM_BUCKETS + 200;

    // Running statistics model plus the queue of expected result words
    class stats_scoreboard;
        logic [DATA_W-1:0] smallest;
        logic [DATA_W-1:0] largest;
        logic [DATA_W-1:0] total_ns;
        logic [DATA_W-1:0] samples;
        logic [DATA_W-1:0] overflows;
        logic [BKT_W-1:0]  hits [NUM_BUCKETS];
        t_result           expected_stats [$];
        int unsigned       mismatches;

        function new();
            mismatches = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            smallest  = '1;
            largest   = '0;
            total_ns  = '0;
            samples   = '0;
            overflows = '0;
            foreach (hits[i]) hits[i] = '0;
        endfunction

        function void take_sample(logic [DATA_W-1:0] s);
            logic [DATA_W-1:0] slot;
            slot = s / DATA_W'(BUCKET_WIDTH_NS);
            if (s < smallest) smallest = s;
            if (s > largest) largest = s;
            total_ns += s;
            samples  += 1;
            if (slot < DATA_W'(NUM_BUCKETS)) begin
                // counters stick at all ones
                if (hits[int'(slot)] != '1) hits[int'(slot)] += 1;
            end else begin
                overflows += 1;
            end
        endfunction

        // First bucket whose cumulative count reaches floor(count * p), else the max
        function logic [DATA_W-1:0] percentile_of(logic [FRAC_W-1:0] frac);
            logic [DATA_W-1:0] p;
            logic [80:0]       product;
            logic [DATA_W-1:0] target;
            logic [DATA_W-1:0] running;
            if (samples == 0) return '0;
            p       = (frac > FRAC_ONE) ? DATA_W'(FRAC_ONE) : DATA_W'(frac);
            product = 81'(samples) * 81'(p);
            target  = product[79:16];
            running = '0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                running += DATA_W'(hits[i]);
                if (running >= target) return DATA_W'(i + 1) * DATA_W'(BUCKET_WIDTH_NS);
            end
            return largest;
        endfunction

        // Apply one accepted command word and queue the result it must produce
        function void note_command(logic [1:0] cmd, logic [DATA_W-1:0] sample,
                                   logic [FRAC_W-1:0] frac);
            t_result want;
            want.percentile_latency = '0;
            case (cmd)
                CMD_RECORD: take_sample(sample);
                CMD_QUERY:  want.percentile_latency = percentile_of(frac);
                CMD_CLEAR:  clear_stats();
                CMD_UNUSED: ;
            endcase
            want.min_latency    = smallest;
            want.max_latency    = largest;
            want.sample_sum     = total_ns;
            want.sample_count   = samples;
            want.overflow_count = overflows;
            want.mean_latency   = (samples == 0) ? '0 : total_ns / samples;
            expected_stats.push_back(want);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 200) $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_stats.size() == 0) begin
                report_mismatch("result word with no command outstanding");
                return;
            end
            want = expected_stats.pop_front();
            check_field("min_latency", got.min_latency, want.min_latency);
            check_field("max_latency", got.max_latency, want.max_latency);
            check_field("sample_sum", got.sample_sum, want.sample_sum);
            check_field("sample_count", got.sample_count, want.sample_count);
            check_field("overflow_count", got.overflow_count, want.overflow_count);
            check_field("mean_latency", got.mean_latency, want.mean_latency);
            check_field("percentile_latency", got.percentile_latency,
                        want.percentile_latency);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    lhs_in_if  in_if();
    lhs_out_if out_if();

    stats_scoreboard stats_book;
    int unsigned     src_idle_pct;
    int unsigned     sink_stall_pct;
    longint unsigned cycle_count  = 0;
    // Grows with every word sent; starts with the reset sweep and the final drain
    longint unsigned cycle_budget = 4 * (NUM_BUCKETS + 100) + 4 * DRAIN_CYCLES + 10000;
    t_result         seen;

    latency_histogram_stats DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_budget) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result receiver: random back-pressure, updated at the falling edge
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.min_latency        = out_if.min_latency;
            seen.max_latency        = out_if.max_latency;
            seen.sample_sum         = out_if.sample_sum;
            seen.sample_count       = out_if.sample_count;
            seen.overflow_count     = out_if.overflow_count;
            seen.mean_latency       = out_if.mean_latency;
            seen.percentile_latency = out_if.percentile_latency;
            stats_book.check_result(seen);
        end
    end

    // Present one command word from a falling edge; returns at the falling edge after accept
    task automatic send_command(logic [1:0] cmd, logic [DATA_W-1:0] sample,
                                logic [FRAC_W-1:0] frac);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        case (cmd)
            CMD_QUERY: cycle_budget += 4 * (2 * NUM_BUCKETS + 100) + 200;
            CMD_CLEAR: cycle_budget += 4 * (NUM_BUCKETS + 80) + 200;
            default:   cycle_budget += 4 * 80 + 200;
        endcase
        in_if.valid        <= 1'b1;
        in_if.command      <= cmd;
        in_if.sample_nanos <= sample;
        in_if.pct_fraction <= frac;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        stats_book.note_command(cmd, sample, frac);
        @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) return DATA_W'($urandom_range(HIST_SPAN_NS - 1));
        if (pick < 70) return DATA_W'($urandom_range(4 * BUCKET_WIDTH_NS));
        // around the end of the histogram
        if (pick < 80) return DATA_W'(HIST_SPAN_NS) - 3 + DATA_W'($urandom_range(5));
        if (pick < 95) return {$urandom, $urandom};
        return $urandom_range(1) ? ALL_ONES : '0;
    endfunction

    function automatic logic [FRAC_W-1:0] random_fraction();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return FRAC_ONE;
        if (pick < 30) return FRAC_W'($urandom_range(2 ** FRAC_W - 1));
        return FRAC_W'($urandom_range(FRAC_ONE));
    endfunction

    // Mostly records, with queries, clears and the unused code mixed in
    task automatic run_phase(int unsigned src_pct, int unsigned sink_pct, int count);
        int unsigned pick;
        logic [1:0]  cmd;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 84) cmd = CMD_RECORD;
            else if (pick < 94) cmd = CMD_QUERY;
            else if (pick < 97) cmd = CMD_CLEAR;
            else cmd = CMD_UNUSED;
            send_command(cmd, random_sample(), random_fraction());
        end
    endtask

    initial begin
        stats_book          = new();
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.command       = CMD_RECORD;
        in_if.sample_nanos  = '0;
        in_if.pct_fraction  = '0;
        src_idle_pct        = 0;
        sink_stall_pct      = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tracker, bucket edges, overflow, sum wrap, fraction extremes
        send_command(CMD_QUERY, {$urandom, $urandom}, FRAC_ONE);
        send_command(CMD_UNUSED, {$urandom, $urandom}, FRAC_W'($urandom));
        send_command(CMD_RECORD, '0, FRAC_W'($urandom));
        send_command(CMD_RECORD, DATA_W'(BUCKET_WIDTH_NS - 1), FRAC_W'($urandom));
        send_command(CMD_RECORD, DATA_W'(BUCKET_WIDTH_NS), FRAC_W'($urandom));
        send_command(CMD_RECORD, DATA_W'(HIST_SPAN_NS - 1), FRAC_W'($urandom));
        send_command(CMD_RECORD, DATA_W'(HIST_SPAN_NS), FRAC_W'($urandom));
        send_command(CMD_RECORD, ALL_ONES, FRAC_W'($urandom));
        send_command(CMD_RECORD, ALL_ONES, FRAC_W'($urandom));
        send_command(CMD_QUERY, {$urandom, $urandom}, '0);
        // too many overflows for any bucket to reach the target: answer is the max
        send_command(CMD_QUERY, {$urandom, $urandom}, FRAC_ONE);
        send_command(CMD_QUERY, {$urandom, $urandom}, '1);
        send_command(CMD_QUERY, {$urandom, $urandom}, FRAC_ONE >> 1);
        send_command(CMD_QUERY, {$urandom, $urandom}, FRAC_W'(1));
        send_command(CMD_UNUSED, ALL_ONES, '1);
        send_command(CMD_CLEAR, {$urandom, $urandom}, FRAC_W'($urandom));
        send_command(CMD_QUERY, {$urandom, $urandom}, FRAC_ONE);
        send_command(CMD_RECORD, DATA_W'(5 * BUCKET_WIDTH_NS), FRAC_W'($urandom));
        send_command(CMD_QUERY, {$urandom, $urandom}, FRAC_ONE);
        send_command(CMD_QUERY, {$urandom, $urandom}, FRAC_ONE + 1);
        send_command(CMD_CLEAR, ALL_ONES, '1);

        // Random traffic under four idling patterns
        run_phase(0, 0, RANDOM_WORDS / 4);
        run_phase(71, 0, RANDOM_WORDS / 4);
        run_phase(0, 71, RANDOM_WORDS / 4);
        run_phase(35, 35, RANDOM_WORDS / 4);
        in_if.valid <= 1'b0;

        // Drain, then give a stray extra result time to show up
        while (stats_book.expected_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (stats_book.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
